/* src/ppfc_pkg.sv */
// ----------------------------------------------------------------------------
// ppfc_pkg
// Shared widths, register indexes, types and helpers for the pinhole
// projection and field-of-view cull block.
// ----------------------------------------------------------------------------
package ppfc_pkg;

  localparam int COORD_W   = 24;   // Q12.12 coordinate
  localparam int ROT_W     = 21;   // Q2.19 matrix entry
  localparam int PIX_W     = 20;   // Q12.8 pixel
  localparam int TAG_W     = 20;
  localparam int DEPTH_W   = 23;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 64;
  localparam int NUM_W     = 44;   // focal times coordinate, signed
  localparam int QUO_W     = 21;   // in-range quotient, signed

  localparam int MAX_POINTS_DEF = 1048576;

  localparam logic [CFG_IDX_W-1:0] REG_ROT_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_Z   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POS_XY  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_POS_Z   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_IMG     = 3'd7;

  localparam logic [62:0] ROT_X_RST = 63'd524288;
  localparam logic [62:0] ROT_Y_RST = 63'd524288 << 21;
  localparam logic [62:0] ROT_Z_RST = 63'd524288 << 42;

  // divider result word
  typedef struct packed {
    logic                    vld;
    logic                    oor;   // floor quotient outside signed 21 bits
    logic signed [QUO_W-1:0] quo;
  } div_res_t;

  function automatic logic signed [COORD_W-1:0] sat24(input logic signed [31:0] v);
    if (v > 32'sd8388607) begin
      return 24'sh7FFFFF;
    end else if (v < -32'sd8388608) begin
      return 24'sh800000;
    end else begin
      return v[COORD_W-1:0];
    end
  endfunction

endpackage

/* src/pinhole_projection_fov_cull_top.sv */
// ----------------------------------------------------------------------------
// pinhole_projection_fov_cull_top
// World point to pixel projection with behind-camera and image-bound culling.
// ----------------------------------------------------------------------------
// Usage:
//  - Input: drive in_world_* and in_point_tag with start high. busy is
//    always low, so one word is taken every cycle that start is high.
//  - Output: out_valid strobes for one cycle per input word, in order, with
//    out_in_view, out_cam_depth, out_pixel_u/v and out_tag_out. The receiver
//    cannot stall; results are never held.
//  - Pipeline: four stages of subtract, multiply, rotate-sum and focal
//    multiply feed the two dividers, 23 one-bit stages each plus entry and
//    result registers, with one output register at the end. Throughput:
//    one word per cycle.
//  - Config: cfg_valid/cfg_index/cfg_data, cfg_ready always high. Write only
//    when the pipe is empty; each stage reads the live registers.
//  - Reset (rst_n low, synchronous): pipe valids clear, registers return to
//    identity rotation and zero for everything else.
// ----------------------------------------------------------------------------
module pinhole_projection_fov_cull_top #(
  parameter int MAX_POINTS = ppfc_pkg::MAX_POINTS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [ppfc_pkg::COORD_W-1:0]  in_world_x,
  input  logic signed [ppfc_pkg::COORD_W-1:0]  in_world_y,
  input  logic signed [ppfc_pkg::COORD_W-1:0]  in_world_z,
  input  logic [ppfc_pkg::TAG_W-1:0]           in_point_tag,
  output logic                                 out_valid,
  output logic                                 out_in_view,
  output logic [ppfc_pkg::DEPTH_W-1:0]         out_cam_depth,
  output logic [ppfc_pkg::PIX_W-1:0]           out_pixel_u,
  output logic [ppfc_pkg::PIX_W-1:0]           out_pixel_v,
  output logic [ppfc_pkg::TAG_W-1:0]           out_tag_out,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ppfc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ppfc_pkg::CFG_DAT_W-1:0]       cfg_data
);
  import ppfc_pkg::*;

  localparam logic [24:0] MAX_P = 25'(MAX_POINTS);

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // ---------------- configuration registers ----------------
  logic [62:0] rot_r [3];
  logic [47:0] pos_xy_r;
  logic [23:0] pos_z_r;
  logic [39:0] focal_r, center_r;
  logic [23:0] img_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_r[0] <= ROT_X_RST;
      rot_r[1] <= ROT_Y_RST;
      rot_r[2] <= ROT_Z_RST;
      pos_xy_r <= '0;
      pos_z_r  <= '0;
      focal_r  <= '0;
      center_r <= '0;
      img_r    <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ROT_X:  rot_r[0] <= cfg_data[62:0];
        REG_ROT_Y:  rot_r[1] <= cfg_data[62:0];
        REG_ROT_Z:  rot_r[2] <= cfg_data[62:0];
        REG_POS_XY: pos_xy_r <= cfg_data[47:0];
        REG_POS_Z:  pos_z_r  <= cfg_data[23:0];
        REG_FOCAL:  focal_r  <= cfg_data[39:0];
        REG_CENTER: center_r <= cfg_data[39:0];
        REG_IMG:    img_r    <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  // ---------------- stage 1: camera-relative difference ----------------
  logic                      v1_r;
  logic signed [COORD_W-1:0] d_r [3];
  logic [TAG_W-1:0]          tag1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start;
    end
    d_r[0] <= sat24(32'(in_world_x) - 32'($signed(pos_xy_r[23:0])));
    d_r[1] <= sat24(32'(in_world_y) - 32'($signed(pos_xy_r[47:24])));
    d_r[2] <= sat24(32'(in_world_z) - 32'($signed(pos_z_r)));
    tag1_r <= in_point_tag;
  end

  // ---------------- stage 2: nine matrix products ----------------
  logic              v2_r;
  logic signed [44:0] prod_r [3][3];
  logic [TAG_W-1:0]  tag2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod_r[i][j] <= d_r[j] * $signed(rot_r[i][ROT_W*j +: ROT_W]);
      end
    end
    tag2_r <= tag1_r;
  end

  // ---------------- stage 3: row sums, round, saturate ----------------
  logic                      v3_r;
  logic signed [COORD_W-1:0] cc_r [3];
  logic [TAG_W-1:0]          tag3_r;
  logic signed [46:0]        acc [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = 47'(prod_r[i][0]) + 47'(prod_r[i][1]) + 47'(prod_r[i][2])
             + 47'sd262144;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
    for (int i = 0; i < 3; i++) begin
      cc_r[i] <= sat24(32'($signed(acc[i][46:19])));
    end
    tag3_r <= tag2_r;
  end

  // ---------------- stage 4: focal products ----------------
  logic                    v4_r, zpos4_r;
  logic signed [NUM_W-1:0] nu_r, nv_r;
  logic [DEPTH_W-1:0]      z4_r;
  logic [TAG_W-1:0]        tag4_r;
  logic signed [44:0]      pu, pv;

  assign pu = $signed({1'b0, focal_r[19:0]}) * cc_r[0];
  assign pv = $signed({1'b0, focal_r[39:20]}) * cc_r[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
    nu_r    <= pu[NUM_W-1:0];
    nv_r    <= pv[NUM_W-1:0];
    zpos4_r <= !cc_r[2][COORD_W-1] && (cc_r[2] != '0);
    z4_r    <= cc_r[2][DEPTH_W-1:0];
    tag4_r  <= tag3_r;
  end

  // ---------------- dividers ----------------
  localparam int SWU = TAG_W + 1;
  div_res_t               ru, rv;
  logic [SWU-1:0]         side_u;
  logic [DEPTH_W-1:0]     side_v;

  ppfc_div #(.SW(SWU)) u_div_u (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (v4_r),
    .in_num   (nu_r),
    .in_den   (z4_r),
    .in_side  ({zpos4_r, tag4_r}),
    .res      (ru),
    .res_side (side_u)
  );

  ppfc_div #(.SW(DEPTH_W)) u_div_v (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (v4_r),
    .in_num   (nv_r),
    .in_den   (z4_r),
    .in_side  (z4_r),
    .res      (rv),
    .res_side (side_v)
  );

  // ---------------- final: principal point, bounds, output ----------------
  logic               zpos;
  logic [TAG_W-1:0]   tag_f;
  logic signed [23:0] u, v;
  logic [19:0]        w256, h256;
  logic               ok;

  assign zpos = side_u[SWU-1];
  assign tag_f = side_u[TAG_W-1:0];
  assign u    = 24'(ru.quo) + $signed({4'b0, center_r[19:0]});
  assign v    = 24'(rv.quo) + $signed({4'b0, center_r[39:20]});
  assign w256 = {img_r[11:0], 8'b0};
  assign h256 = {img_r[23:12], 8'b0};
  assign ok   = zpos && !ru.oor && !rv.oor
             && !u[23] && (u[22:0] <= 23'(w256))
             && !v[23] && (v[22:0] <= 23'(h256))
             && ({5'b0, tag_f} < MAX_P);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= ru.vld;
    end
    out_in_view   <= ok;
    out_cam_depth <= zpos ? side_v : '0;
    out_pixel_u   <= ok ? u[PIX_W-1:0] : '0;
    out_pixel_v   <= ok ? v[PIX_W-1:0] : '0;
    out_tag_out   <= tag_f;
  end

  // rv.vld tracks ru.vld; the u path carries the strobe
  logic unused_vld;
  assign unused_vld = rv.vld;

endmodule

/* src/ppfc_div.sv */
// ----------------------------------------------------------------------------
// ppfc_div
// Pipelined restoring divider: signed numerator over positive divisor,
// floor quotient, one quotient bit per stage, range flag on the result.
// ----------------------------------------------------------------------------
module ppfc_div #(
  parameter int SW = 1
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_vld,
  input  logic signed [ppfc_pkg::NUM_W-1:0]      in_num,
  input  logic [ppfc_pkg::DEPTH_W-1:0]           in_den,
  input  logic [SW-1:0]                          in_side,
  output ppfc_pkg::div_res_t                     res,
  output logic [SW-1:0]                          res_side
);
  import ppfc_pkg::*;

  localparam int QW    = 23;                 // top bit flags overflow
  localparam int MAG_W = NUM_W - 1;
  localparam int CMP_W = DEPTH_W + QW;

  logic                   vld_r  [QW+1];
  logic                   sgn_r  [QW+1];
  logic [MAG_W-1:0]       rem_r  [QW+1];
  logic [QW-1:0]          q_r    [QW+1];
  logic [DEPTH_W-1:0]     den_r  [QW+1];
  logic [SW-1:0]          side_r [QW+1];

  logic [NUM_W-1:0] abs_num;
  assign abs_num = in_num[NUM_W-1] ? (~in_num + 1'b1) : in_num;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
    end
    sgn_r[0]  <= in_num[NUM_W-1];
    rem_r[0]  <= abs_num[MAG_W-1:0];
    q_r[0]    <= '0;
    den_r[0]  <= in_den;
    side_r[0] <= in_side;
  end

  for (genvar k = 1; k <= QW; k++) begin : g_stage
    localparam int B = QW - k;
    logic [CMP_W-1:0] rem_ext, sub;
    logic             take;
    assign rem_ext = CMP_W'(rem_r[k-1]);
    assign sub     = CMP_W'(den_r[k-1]) << B;
    assign take    = rem_ext >= sub;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_r[k-1];
      end
      sgn_r[k]  <= sgn_r[k-1];
      den_r[k]  <= den_r[k-1];
      side_r[k] <= side_r[k-1];
      rem_r[k]  <= take ? MAG_W'(rem_ext - sub) : rem_r[k-1];
      q_r[k]    <= q_r[k-1] | (take ? (QW'(1) << B) : '0);
    end
  end

  // floor correction and range check
  logic [QW-2:0] qmag;
  logic [QW-1:0] nmag;
  logic          rnz, ovf, oor;
  logic signed [QUO_W-1:0] quo;
  assign qmag = q_r[QW][QW-2:0];
  assign ovf  = q_r[QW][QW-1];
  assign rnz  = |rem_r[QW];
  assign nmag = {1'b0, qmag} + QW'(rnz);

  always_comb begin
    if (sgn_r[QW]) begin
      oor = ovf || (nmag > QW'(1048576));
      quo = QUO_W'(-$signed(nmag));
    end else begin
      oor = ovf || (qmag[QW-2:QUO_W-1] != '0);
      quo = $signed({1'b0, qmag[QUO_W-2:0]});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res.vld <= 1'b0;
    end else begin
      res.vld <= vld_r[QW];
    end
    res.oor  <= oor;
    res.quo  <= quo;
    res_side <= side_r[QW];
  end

endmodule
